/* rtl/bdch_pkg.sv */
// Package with the shared types and register indexes of the button debouncer.
`timescale 1ns / 1ps
`default_nettype none
package bdch_pkg;

   // Configuration register indexes, in register map order.
   localparam logic [1:0] CSR_PRESSED_IS_HIGH = 2'd0;
   localparam logic [1:0] CSR_DEBOUNCE_MS     = 2'd1;
   localparam logic [1:0] CSR_CLICK_WINDOW_MS = 2'd2;
   localparam logic [1:0] CSR_HOLD_MS         = 2'd3;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 15;

   localparam logic [7:0] CLICK_COUNT_MAX = 8'd255;

   // One poll of the button pin.
   typedef struct packed {
      logic        pin_level;
      logic [31:0] now_ms;
      logic        take_click;
   } req_type;

   // One status report.
   typedef struct packed {
      logic       pressed;
      logic       click_event;
      logic [7:0] click_count;
      logic       clicking;
      logic       holding;
   } rsp_type;

   // Configuration as seen by the debounce core.
   typedef struct packed {
      logic        pressed_is_high;
      logic [7:0]  debounce_ms;
      logic [14:0] click_window_ms;
      logic [14:0] hold_ms;
   } cfg_type;

endpackage
`default_nettype wire

/* rtl/bdch_req_if.sv */
// Request channel interface: one poll of the button pin per request.
`timescale 1ns / 1ps
`default_nettype none
interface bdch_req_if;
   logic        valid;
   logic        ready;
   logic        pin_level;
   logic [31:0] now_ms;
   logic        take_click;

   modport source (output valid, output pin_level, output now_ms, output take_click,
                   input ready);
   modport sink   (input valid, input pin_level, input now_ms, input take_click,
                   output ready);
endinterface
`default_nettype wire

/* rtl/bdch_rsp_if.sv */
// Response channel interface: one button status report per request.
`timescale 1ns / 1ps
`default_nettype none
interface bdch_rsp_if;
   logic       valid;
   logic       ready;
   logic       pressed;
   logic       click_event;
   logic [7:0] click_count;
   logic       clicking;
   logic       holding;

   modport source (output valid, output pressed, output click_event, output click_count,
                   output clicking, output holding, input ready);
   modport sink   (input valid, input pressed, input click_event, input click_count,
                   input clicking, input holding, output ready);
endinterface
`default_nettype wire

/* rtl/bdch_csr_if.sv */
// Configuration write channel interface.
`timescale 1ns / 1ps
`default_nettype none
interface bdch_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [14:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/bdch_csr.sv */
// Configuration register file of the button debouncer.
`timescale 1ns / 1ps
`default_nettype none
module bdch_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            wr_en,
   input  wire logic [bdch_pkg::CSR_INDEX_W-1:0] wr_index,
   input  wire logic [bdch_pkg::CSR_DATA_W-1:0]  wr_data,
   output bdch_pkg::cfg_type                    cfg
);
   import bdch_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index and replace the addressed field.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_PRESSED_IS_HIGH: cfg_in.pressed_is_high = wr_data[0];
            CSR_DEBOUNCE_MS:     cfg_in.debounce_ms     = wr_data[7:0];
            CSR_CLICK_WINDOW_MS: cfg_in.click_window_ms = wr_data[14:0];
            CSR_HOLD_MS:         cfg_in.hold_ms         = wr_data[14:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // Registers with their documented reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pressed_is_high <= 1'b1;
         cfg_ff.debounce_ms     <= 8'd50;
         cfg_ff.click_window_ms <= 15'd300;
         cfg_ff.hold_ms         <= 15'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* rtl/bdch_core.sv */
// Debounce, click counting and hold detection state with its update logic.
`timescale 1ns / 1ps
`default_nettype none
module bdch_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire bdch_pkg::cfg_type cfg,
   input  wire bdch_pkg::req_type req,
   output bdch_pkg::rsp_type      rsp
);
   import bdch_pkg::*;

   // Last click time doubles as the hold start time: both are set together.
   logic        was_released_ff, was_released_in;
   logic        debouncing_ff,   debouncing_in;
   logic [31:0] press_start_ff,  press_start_in;
   logic [31:0] click_time_ff,   click_time_in;
   logic        pressed_ff,      pressed_in;
   logic        click_flag_ff,   click_flag_in;
   logic [7:0]  click_count_ff,  click_count_in;
   logic        hold_ff,         hold_in;

   logic        is_pressed;
   logic        start_debounce;
   logic        deb_mid;
   logic [31:0] elapsed;
   logic        confirm;
   logic        click_flag_mid;
   logic [7:0]  count_mid;
   logic [31:0] since_click;
   logic        window_expired;
   logic        clicking;

   // Press detection and debounce timing.
   always_comb begin
      is_pressed      = (req.pin_level == cfg.pressed_is_high);
      start_debounce  = is_pressed && was_released_ff && !debouncing_ff;
      deb_mid         = debouncing_ff || start_debounce;
      elapsed         = start_debounce ? 32'd0 : (req.now_ms - press_start_ff);
      confirm         = deb_mid && (elapsed >= {24'd0, cfg.debounce_ms});
      was_released_in = !is_pressed;
      press_start_in  = start_debounce ? req.now_ms : press_start_ff;
      // A pending press is cancelled by a released poll unless it is confirmed.
      debouncing_in   = deb_mid && !confirm && is_pressed;
   end

   // Click flag, click count and click window.
   always_comb begin
      pressed_in     = confirm || (is_pressed && pressed_ff);
      click_flag_mid = confirm || (is_pressed && click_flag_ff);
      count_mid      = click_count_ff;
      if (confirm && (click_count_ff != CLICK_COUNT_MAX)) begin
         count_mid = click_count_ff + 8'd1;
      end
      click_time_in  = confirm ? req.now_ms : click_time_ff;
      since_click    = confirm ? 32'd0 : (req.now_ms - click_time_ff);
      window_expired = (count_mid != 8'd0) && (since_click > {17'd0, cfg.click_window_ms});
      click_count_in = window_expired ? 8'd0 : count_mid;
      clicking       = (click_count_in != 8'd0);
      click_flag_in  = click_flag_mid && !req.take_click;
   end

   // Hold detection while the debounced press lasts.
   always_comb begin
      hold_in = hold_ff;
      if (!pressed_in) begin
         hold_in = 1'b0;
      end else if (since_click > {17'd0, cfg.hold_ms}) begin
         hold_in = 1'b1;
      end
   end

   // Status report for this request.
   always_comb begin
      rsp.pressed     = pressed_in;
      rsp.click_event = click_flag_mid;
      rsp.click_count = click_count_in;
      rsp.clicking    = clicking;
      rsp.holding     = hold_in;
   end

   // State registers advance once per request.
   always_ff @(posedge clock) begin
      if (reset) begin
         was_released_ff <= 1'b0;
         debouncing_ff   <= 1'b0;
         press_start_ff  <= 32'd0;
         click_time_ff   <= 32'd0;
         pressed_ff      <= 1'b0;
         click_flag_ff   <= 1'b0;
         click_count_ff  <= 8'd0;
         hold_ff         <= 1'b0;
      end else if (advance) begin
         was_released_ff <= was_released_in;
         debouncing_ff   <= debouncing_in;
         press_start_ff  <= press_start_in;
         click_time_ff   <= click_time_in;
         pressed_ff      <= pressed_in;
         click_flag_ff   <= click_flag_in;
         click_count_ff  <= click_count_in;
         hold_ff         <= hold_in;
      end
   end

   // A hold is only ever reported during a debounced press.
   a_hold_needs_press: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> pressed_ff)
      else $error("hold flag set without a debounced press");

   // A confirmed press always leaves a nonzero click count behind.
   a_confirm_counts: assert property (@(posedge clock) disable iff (reset)
      advance && confirm |=> click_count_ff != 8'd0)
      else $error("confirmed press left the click count at zero");

   // A released poll never leaves a debounce pending.
   a_release_cancels: assert property (@(posedge clock) disable iff (reset)
      advance && !is_pressed |=> !debouncing_ff && was_released_ff)
      else $error("debounce still pending after a released poll");

   // A pending click event implies the button is still down.
   a_event_needs_press: assert property (@(posedge clock) disable iff (reset)
      click_flag_ff |-> pressed_ff)
      else $error("click event pending while released");

endmodule
`default_nettype wire

/* rtl/button_debounce_click_hold.sv */
// Top level of the button debouncer with multi-click counting and hold detection.
//
//   Channel   Direction  Handshake      Payload
//   req_ch    in         valid/ready    pin_level, now_ms, take_click
//   rsp_ch    out        valid/ready    pressed, click_event, click_count, clicking, holding
//   csr_ch    in         valid/ready    index, data (always ready)
//
// A response is presented from the response register: an accepted request waits in the request
// register, which feeds the state update that loads the response register when its slot is free.
// A request can be accepted on every cycle while responses are taken.
// Reset restores the register defaults and clears all button state.
// When the response is stalled, one more request is still held in the request register.
`timescale 1ns / 1ps
`default_nettype none
module button_debounce_click_hold (
   input  wire logic  clock,
   input  wire logic  reset,
   bdch_req_if.sink   req_ch,
   bdch_rsp_if.source rsp_ch,
   bdch_csr_if.sink   csr_ch
);
   import bdch_pkg::*;

   cfg_type cfg;
   req_type req_ff;
   logic    req_valid_ff, req_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_next;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    advance;

   // Configuration registers.
   assign csr_ch.ready = 1'b1;

   bdch_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   // Pipeline flow control: the request moves on when the response slot frees up.
   always_comb begin
      advance      = req_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
      req_ch.ready = !req_valid_ff || advance;
      req_valid_in = req_ch.valid || (req_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         req_ff.pin_level  <= req_ch.pin_level;
         req_ff.now_ms     <= req_ch.now_ms;
         req_ff.take_click <= req_ch.take_click;
      end
   end

   // Button state and its update.
   bdch_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .req     (req_ff),
      .rsp     (rsp_next)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pressed     = rsp_ff.pressed;
   assign rsp_ch.click_event = rsp_ff.click_event;
   assign rsp_ch.click_count = rsp_ff.click_count;
   assign rsp_ch.clicking    = rsp_ff.clicking;
   assign rsp_ch.holding     = rsp_ff.holding;

endmodule
`default_nettype wire

/* dv/bdch_status_checker.sv */
// Checker that mirrors the button debouncer state and compares every status report.
`timescale 1ns / 1ps
module bdch_status_checker (
   input  logic        clock,
   input  logic        reset,
   bdch_req_if         req_ch,
   bdch_rsp_if         rsp_ch,
   bdch_csr_if         csr_ch,
   output int unsigned failures,
   output int unsigned pending
);
   import bdch_pkg::*;

   // Mirrored configuration and button state.
   cfg_type     settings;
   logic        released_seen;
   logic        debouncing;
   logic        down_flag;
   logic        event_flag;
   logic        window_open;
   logic        hold_flag;
   logic [31:0] press_start;
   logic [31:0] last_click;
   logic [31:0] hold_start;
   logic [7:0]  clicks;

   // Status reports still owed by the block, oldest first.
   rsp_type     status_due[$];
   int unsigned mismatches = 0;
   int unsigned due_count = 0;

   assign failures = mismatches;
   assign pending  = due_count;

   // Advance the mirrored state by one poll and return the status it reports.
   function automatic rsp_type next_status(input req_type poll);
      rsp_type     status;
      logic        is_down;
      logic [31:0] since_press;
      logic [31:0] since_click;
      logic [31:0] since_hold;
      is_down = (poll.pin_level == settings.pressed_is_high);
      if (!is_down) begin
         released_seen = 1'b1;
         down_flag     = 1'b0;
         event_flag    = 1'b0;
      end
      // A debounce only starts on the first pressed poll after a release.
      if (is_down && released_seen) begin
         if (!debouncing) begin
            debouncing  = 1'b1;
            press_start = poll.now_ms;
         end
         released_seen = 1'b0;
      end

      // A press that has lasted long enough is confirmed, even on a release poll.
      since_press = poll.now_ms - press_start;
      if (debouncing && since_press >= 32'(settings.debounce_ms)) begin
         event_flag  = 1'b1;
         down_flag   = 1'b1;
         debouncing  = 1'b0;
         if (clicks != CLICK_COUNT_MAX) begin
            clicks = clicks + 8'd1;
         end
         window_open = 1'b1;
         last_click  = poll.now_ms;
         hold_start  = poll.now_ms;
      end else if (debouncing && released_seen) begin
         debouncing = 1'b0;
      end

      // The click count clears once the window since the last click has run out.
      since_click = poll.now_ms - last_click;
      if (clicks != 8'd0 && since_click > 32'(settings.click_window_ms)) begin
         clicks      = 8'd0;
         window_open = 1'b0;
      end else begin
         window_open = (clicks != 8'd0);
      end

      since_hold = poll.now_ms - hold_start;
      if (down_flag && since_hold > 32'(settings.hold_ms)) begin
         hold_flag = 1'b1;
      end else if (!down_flag) begin
         hold_flag = 1'b0;
      end

      status.pressed     = down_flag;
      status.click_event = event_flag;
      status.click_count = clicks;
      status.clicking    = window_open;
      status.holding     = hold_flag;

      // The click event is cleared only after it has been reported.
      if (poll.take_click) begin
         event_flag = 1'b0;
      end
      return status;
   endfunction

   // Watch all three channels; responses are checked before this edge's request is predicted.
   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      req_type poll;
      if (reset) begin
         settings.pressed_is_high = 1'b1;
         settings.debounce_ms     = 8'd50;
         settings.click_window_ms = 15'd300;
         settings.hold_ms         = 15'd1000;
         released_seen = 1'b0;
         debouncing    = 1'b0;
         down_flag     = 1'b0;
         event_flag    = 1'b0;
         window_open   = 1'b0;
         hold_flag     = 1'b0;
         press_start   = 32'd0;
         last_click    = 32'd0;
         hold_start    = 32'd0;
         clicks        = 8'd0;
         status_due.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.pressed     = rsp_ch.pressed;
            seen.click_event = rsp_ch.click_event;
            seen.click_count = rsp_ch.click_count;
            seen.clicking    = rsp_ch.clicking;
            seen.holding     = rsp_ch.holding;
            if (status_due.size() == 0) begin
               mismatches++;
               $display("%0t: status report with no request outstanding", $time);
            end else begin
               want = status_due.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  $display({"%0t: status mismatch: expected pressed %0d event %0d count %0d",
                            " clicking %0d holding %0d, got pressed %0d event %0d count %0d",
                            " clicking %0d holding %0d"}, $time,
                           want.pressed, want.click_event, want.click_count, want.clicking,
                           want.holding, seen.pressed, seen.click_event, seen.click_count,
                           seen.clicking, seen.holding);
               end
            end
         end

         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_PRESSED_IS_HIGH: settings.pressed_is_high = csr_ch.data[0];
               CSR_DEBOUNCE_MS:     settings.debounce_ms     = csr_ch.data[7:0];
               CSR_CLICK_WINDOW_MS: settings.click_window_ms = csr_ch.data;
               CSR_HOLD_MS:         settings.hold_ms         = csr_ch.data;
               default: ;
            endcase
         end

         if (req_ch.valid && req_ch.ready) begin
            poll.pin_level  = req_ch.pin_level;
            poll.now_ms     = req_ch.now_ms;
            poll.take_click = req_ch.take_click;
            status_due.push_back(next_status(poll));
         end
      end
      due_count = status_due.size();
   end

endmodule

/* dv/tb.sv */
// Testbench top: drives polls and register writes into the debouncer and gives the verdict.
`timescale 1ns / 1ps
module tb;
   import bdch_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam logic [31:0] NEAR_WRAP   = 32'hFFFF_FF00;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned failures;
   int unsigned pending;
   int unsigned burst_left = 0;
   int unsigned cycles = 0;
   logic [31:0] stamp;

   // Configuration currently programmed, used to shape the polls.
   logic        cur_pol  = 1'b1;
   logic [7:0]  cur_deb  = 8'd50;
   logic [14:0] cur_win  = 15'd300;
   logic [14:0] cur_hold = 15'd1000;

   bdch_req_if req_ch ();
   bdch_rsp_if rsp_ch ();
   bdch_csr_if csr_ch ();

   button_debounce_click_hold dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   bdch_status_checker status_check (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_ch   (csr_ch),
      .failures (failures),
      .pending  (pending)
   );

   always #1 clock = ~clock;

   // Run guard: a hung handshake ends the run.
   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Response side: ready follows a changing mix of always ready, random and stall bursts.
   initial begin
      int unsigned mode;
      int unsigned mode_left;
      int unsigned stall_len;
      mode      = 0;
      mode_left = 0;
      stall_len = 1;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 150);
            stall_len = $urandom_range(1, 8);
         end
         mode_left--;
         case (mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            default: rsp_ch.ready <= ((mode_left % 9) >= stall_len);
         endcase
      end
   end

   // Send one request; gaps fall only between bursts, so valid stays high inside a burst.
   task automatic send_poll(input logic level, input logic [31:0] now, input logic take);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_ch.valid      <= 1'b1;
      req_ch.pin_level  <= level;
      req_ch.now_ms     <= now;
      req_ch.take_click <= take;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [14:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Program all four registers; unused upper data bits carry noise.
   task automatic configure(input logic pol, input logic [7:0] deb, input logic [14:0] win,
                            input logic [14:0] hold);
      write_reg(CSR_PRESSED_IS_HIGH, {14'($urandom), pol});
      write_reg(CSR_DEBOUNCE_MS, {7'($urandom), deb});
      write_reg(CSR_CLICK_WINDOW_MS, win);
      write_reg(CSR_HOLD_MS, hold);
      csr_ch.valid <= 1'b0;
      cur_pol  = pol;
      cur_deb  = deb;
      cur_win  = win;
      cur_hold = hold;
   endtask

   // Stop sending and wait until every request has had its response.
   task automatic drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
   endtask

   // Press and release the button in segments; time steps land on the timer boundaries often.
   task automatic run_polls(input int unsigned count, input bit flip_each);
      int unsigned seg_left;
      logic        down;
      logic        level;
      logic [31:0] step;
      down     = 1'b0;
      seg_left = 0;
      for (int unsigned n = 0; n < count; n++) begin
         if (seg_left == 0) begin
            down     = ~down;
            seg_left = flip_each ? 1 : $urandom_range(1, 12);
         end
         seg_left--;
         if (flip_each) begin
            step = $urandom_range(0, 3);
         end else begin
            case ($urandom_range(0, 15))
               0:  step = 32'd0;
               1:  step = 32'd1;
               2:  step = 32'(cur_deb) - 32'(cur_deb != 8'd0);
               3:  step = 32'(cur_deb);
               4:  step = 32'(cur_hold);
               5:  step = 32'(cur_hold) + 32'd1;
               6:  step = 32'(cur_win);
               7:  step = 32'(cur_win) + 32'd1;
               8, 9, 10: step = $urandom_range(0, 32'(cur_deb) + 4);
               11, 12:   step = $urandom_range(0, 64);
               13: step = $urandom_range(0, 32'(cur_hold) + 2);
               14: step = $urandom_range(0, 32'(cur_win) + 2);
               default: step = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 500);
            endcase
         end
         stamp = stamp + step;
         level = down ? cur_pol : ~cur_pol;
         // Contact bounce: a lone poll at the opposite level.
         if (!flip_each && $urandom_range(0, 9) == 0) begin
            level = ~level;
         end
         send_poll(level, stamp, ($urandom_range(0, 2) == 0));
      end
   endtask

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.pin_level  = 1'b0;
      req_ch.now_ms     = 32'd0;
      req_ch.take_click = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_PRESSED_IS_HIGH;
      csr_ch.data       = 15'd0;
      stamp             = 32'd0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed polls at the reset settings, across the time stamp wrap.
      send_poll(1'b0, NEAR_WRAP, 1'b0);
      send_poll(1'b1, NEAR_WRAP + 32'd10, 1'b0);
      send_poll(1'b1, NEAR_WRAP + 32'd59, 1'b0);
      send_poll(1'b1, NEAR_WRAP + 32'd60, 1'b0);
      send_poll(1'b1, NEAR_WRAP + 32'd61, 1'b1);
      send_poll(1'b1, NEAR_WRAP + 32'd62, 1'b0);
      send_poll(1'b1, NEAR_WRAP + 32'd1060, 1'b0);
      send_poll(1'b1, NEAR_WRAP + 32'd1061, 1'b1);
      send_poll(1'b0, NEAR_WRAP + 32'd1070, 1'b0);
      // A release before the debounce time cancels the press.
      send_poll(1'b1, NEAR_WRAP + 32'd1080, 1'b0);
      send_poll(1'b0, NEAR_WRAP + 32'd1100, 1'b0);
      // A release after the debounce time still confirms the press.
      send_poll(1'b1, NEAR_WRAP + 32'd1200, 1'b0);
      send_poll(1'b0, NEAR_WRAP + 32'd1260, 1'b1);
      send_poll(1'b0, NEAR_WRAP + 32'd1270, 1'b0);
      send_poll(1'b1, NEAR_WRAP + 32'd1280, 1'b0);
      send_poll(1'b1, NEAR_WRAP + 32'd1330, 1'b0);
      send_poll(1'b0, NEAR_WRAP + 32'd1340, 1'b0);
      send_poll(1'b1, NEAR_WRAP + 32'd1350, 1'b0);
      send_poll(1'b1, NEAR_WRAP + 32'd1400, 1'b1);
      // Click window boundary: still open at the window, cleared one past it.
      send_poll(1'b0, NEAR_WRAP + 32'd1700, 1'b0);
      send_poll(1'b0, NEAR_WRAP + 32'd1701, 1'b0);
      send_poll(1'b1, 32'h0000_0000, 1'b1);
      send_poll(1'b1, 32'hFFFF_FFFF, 1'b0);
      send_poll(1'b0, 32'h7FFF_FFFF, 1'b1);
      drain();

      // Random phases, starting with the extreme settings.
      configure(1'b0, 8'd0, 15'd0, 15'd0);
      stamp = $urandom;
      run_polls(70, 1'b0);
      drain();
      configure(1'b1, 8'd255, 15'd32767, 15'd32767);
      stamp = $urandom;
      run_polls(70, 1'b0);
      drain();
      repeat (6) begin
         configure(1'($urandom),
                   ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 60)),
                   ($urandom_range(0, 2) == 0) ? 15'($urandom) : 15'($urandom_range(0, 400)),
                   ($urandom_range(0, 2) == 0) ? 15'($urandom) : 15'($urandom_range(0, 1200)));
         stamp = $urandom;
         run_polls(70, 1'b0);
         drain();
      end

      // A press on every other poll inside a wide window drives the count into saturation.
      configure(1'($urandom), 8'd0, 15'd32767, 15'($urandom_range(0, 20)));
      stamp = $urandom;
      run_polls(540, 1'b1);
      drain();

      repeat (10) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
